### design/dcm_renormalize_core_assert.svh
// ----------------------------------------------------------------------------
// dcm renormalize assertion macros
// concurrent assertion wrappers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef DCM_RENORMALIZE_CORE_ASSERT_SVH
`define DCM_RENORMALIZE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DCM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dcm assertion failed");
`define DCM_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dcm assertion failed");
`else
`define DCM_ASSERT(lbl, clk, rstn, prop)
`define DCM_ASSERT_NR(lbl, clk, prop)
`endif
`endif

### design/dcm_pkg.sv
// ----------------------------------------------------------------------------
// dcm_pkg
// shared widths, types and constants of the renormalize core
// ----------------------------------------------------------------------------
`default_nettype none
package dcm_pkg;
    localparam int FRAC_BITS = 14;
    localparam int DW        = 16;
    localparam int EW        = 2 * DW + 1;
    localparam int PCW       = DW + EW;
    localparam int XW        = 2 * DW + 1;
    localparam int MW        = 2 * DW;
    localparam int SW        = 2 * MW;
    localparam int QW        = FRAC_BITS + 1;
    localparam int RW        = 2 * FRAC_BITS + SW + 5;
    localparam int NW        = QW + SW + 2;
    localparam int NLANE     = 9;
    localparam int FRONT_LAT = 7;
    localparam int LANE_LAT  = QW + 3;
    localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT + 1;

    typedef logic signed [DW-1:0] t_data;
    typedef logic signed [XW-1:0] t_elem;
    typedef logic [SW-1:0]        t_sum;
    typedef logic [QW-1:0]        t_q;

    localparam t_data ONE = t_data'(64'd1 << FRAC_BITS);
endpackage
`default_nettype wire

### design/dcm_renormalize_core.sv
// ----------------------------------------------------------------------------
// dcm_renormalize_core
// direction cosine matrix re-orthonormalization from its first two rows
// ----------------------------------------------------------------------------
// Takes one matrix per cycle while not stalled and returns the nine unit-row
// elements after correction, cross product and squared lengths, then the nine
// element lanes, whose exact nearest rounding resolves one result bit per stage
// over FRAC_BITS+1 stages, and then the output register. Transfers stop only
// while a result sits in the output register with i_stall high. When either
// row or their cross product has zero length, the identity returns with o_degenerate set.
`default_nettype none
`include "dcm_renormalize_core_assert.svh"
module dcm_renormalize_core import dcm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_data i_row_a_x,
    input  t_data i_row_a_y,
    input  t_data i_row_a_z,
    input  t_data i_row_b_x,
    input  t_data i_row_b_y,
    input  t_data i_row_b_z,
    output logic  o_valid,
    input  logic  i_stall,
    output t_data o_out_a_x,
    output t_data o_out_a_y,
    output t_data o_out_a_z,
    output t_data o_out_b_x,
    output t_data o_out_b_y,
    output t_data o_out_b_z,
    output t_data o_out_c_x,
    output t_data o_out_c_y,
    output t_data o_out_c_z,
    output logic  o_degenerate
);
    localparam int LANE_END = FRONT_LAT + LANE_LAT - 1;

    logic  r_vld [TOTAL_LAT];
    logic  r_dg  [LANE_LAT];
    t_data r_o   [NLANE];
    logic  r_o_dg;

    logic  w_en;
    t_data w_a [3];
    t_data w_b [3];
    t_elem w_x [NLANE];
    t_sum  w_s [NLANE];
    logic  w_degen;
    t_data w_q [NLANE];
    t_data n_o [NLANE];

    assign w_en    = !(r_vld[TOTAL_LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign w_a     = '{i_row_a_x, i_row_a_y, i_row_a_z};
    assign w_b     = '{i_row_b_x, i_row_b_y, i_row_b_z};

    dcm_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_x     (w_x),
        .o_s     (w_s),
        .o_degen (w_degen)
    );

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        dcm_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_x[l]),
            .i_s   (w_s[l]),
            .o_q   (w_q[l])
        );
    end

    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            if (r_dg[LANE_LAT-1]) begin
                n_o[i] = (i % 4 == 0) ? ONE : '0;
            end else begin
                n_o[i] = w_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TOTAL_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < TOTAL_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dg[0] <= w_degen;
            for (int i = 1; i < LANE_LAT; i++) begin
                r_dg[i] <= r_dg[i-1];
            end
            r_o    <= n_o;
            r_o_dg <= r_dg[LANE_LAT-1];
        end
    end

    assign o_valid      = r_vld[TOTAL_LAT-1];
    assign o_out_a_x    = r_o[0];
    assign o_out_a_y    = r_o[1];
    assign o_out_a_z    = r_o[2];
    assign o_out_b_x    = r_o[3];
    assign o_out_b_y    = r_o[4];
    assign o_out_b_z    = r_o[5];
    assign o_out_c_x    = r_o[6];
    assign o_out_c_y    = r_o[7];
    assign o_out_c_z    = r_o[8];
    assign o_degenerate = r_o_dg;

    `DCM_ASSERT(a_degen_identity, i_clk, i_rst_n, o_valid && o_degenerate |-> o_out_a_x == ONE && o_out_b_y == ONE && o_out_c_z == ONE && o_out_a_y == '0)
    `DCM_ASSERT(a_lane_bound, i_clk, i_rst_n, r_vld[LANE_END] && !r_dg[LANE_LAT-1] |-> w_q[0] <= ONE && w_q[0] >= -ONE)
    `DCM_ASSERT(a_flow, i_clk, i_rst_n, w_en && r_vld[TOTAL_LAT-2] |=> o_valid)
endmodule
`default_nettype wire

### design/dcm_front.sv
// ----------------------------------------------------------------------------
// dcm_front
// orthogonality correction, cross product and squared row lengths
// ----------------------------------------------------------------------------
`default_nettype none
module dcm_front import dcm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_data i_a [3],
    input  t_data i_b [3],
    output t_elem o_x [NLANE],
    output t_sum  o_s [NLANE],
    output logic  o_degen
);
    localparam logic signed [PCW+1:0] SMAX = (PCW+2)'(2 ** (DW - 1) - 1);
    localparam logic signed [PCW+1:0] SMIN = -(PCW+2)'(2 ** (DW - 1));

    t_data r1_a [3];
    t_data r1_b [3];
    logic signed [EW-1:0] r1_e;
    t_data r2_a [3];
    t_data r2_b [3];
    logic signed [PCW-1:0] r2_pa [3];
    logic signed [PCW-1:0] r2_pb [3];
    t_data r3_ap [3];
    t_data r3_bp [3];
    t_data r4_ap [3];
    t_data r4_bp [3];
    logic signed [MW-1:0] r4_p [6];
    logic [MW-1:0] r4_qa [3];
    logic [MW-1:0] r4_qb [3];
    t_data r5_ap [3];
    t_data r5_bp [3];
    t_elem r5_c [3];
    t_sum  r5_sa;
    t_sum  r5_sb;
    t_data r6_ap [3];
    t_data r6_bp [3];
    t_elem r6_c [3];
    t_sum  r6_sa;
    t_sum  r6_sb;
    t_sum  r6_cq [3];
    t_elem r7_x [NLANE];
    t_sum  r7_s [NLANE];
    logic  r7_degen;

    logic signed [EW-1:0] n1_e;
    t_data n3_ap [3];
    t_data n3_bp [3];
    logic signed [MW-1:0] n4_p [6];
    t_sum  n6_cq [3];
    t_sum  n7_sc;

    function automatic t_data corr(input t_data x, input logic signed [PCW-1:0] v);
        logic [PCW-1:0] mag;
        logic [PCW-1:0] r;
        logic signed [PCW+1:0] sr;
        logic signed [PCW+1:0] d;
        mag = v[PCW-1] ? (~v + 1'b1) : v;
        r   = (mag + (PCW'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
        sr  = $signed({2'b00, r});
        d   = (PCW+2)'(x) - (v[PCW-1] ? -sr : sr);
        if (d > SMAX) begin
            return t_data'(SMAX);
        end else if (d < SMIN) begin
            return t_data'(SMIN);
        end
        return t_data'(d);
    endfunction

    always_comb begin
        n1_e = EW'(i_a[0]) * EW'(i_b[0]) + EW'(i_a[1]) * EW'(i_b[1])
             + EW'(i_a[2]) * EW'(i_b[2]);
        for (int i = 0; i < 3; i++) begin
            n3_ap[i] = corr(r2_a[i], r2_pa[i]);
            n3_bp[i] = corr(r2_b[i], r2_pb[i]);
        end
        n4_p[0] = MW'(r3_ap[1]) * MW'(r3_bp[2]);
        n4_p[1] = MW'(r3_ap[2]) * MW'(r3_bp[1]);
        n4_p[2] = MW'(r3_ap[2]) * MW'(r3_bp[0]);
        n4_p[3] = MW'(r3_ap[0]) * MW'(r3_bp[2]);
        n4_p[4] = MW'(r3_ap[0]) * MW'(r3_bp[1]);
        n4_p[5] = MW'(r3_ap[1]) * MW'(r3_bp[0]);
        for (int i = 0; i < 3; i++) begin
            logic [XW-1:0] cm;
            cm = r5_c[i][XW-1] ? XW'(-r5_c[i]) : XW'(r5_c[i]);
            n6_cq[i] = SW'(cm[MW-1:0]) * SW'(cm[MW-1:0]);
        end
        n7_sc = r6_cq[0] + r6_cq[1] + r6_cq[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a <= i_a;
            r1_b <= i_b;
            r1_e <= n1_e;
            r2_a <= r1_a;
            r2_b <= r1_b;
            for (int i = 0; i < 3; i++) begin
                r2_pa[i] <= PCW'(r1_b[i]) * PCW'(r1_e);
                r2_pb[i] <= PCW'(r1_a[i]) * PCW'(r1_e);
            end
            r3_ap <= n3_ap;
            r3_bp <= n3_bp;
            r4_ap <= r3_ap;
            r4_bp <= r3_bp;
            r4_p  <= n4_p;
            for (int i = 0; i < 3; i++) begin
                r4_qa[i] <= MW'(MW'(r3_ap[i]) * MW'(r3_ap[i]));
                r4_qb[i] <= MW'(MW'(r3_bp[i]) * MW'(r3_bp[i]));
            end
            r5_ap   <= r4_ap;
            r5_bp   <= r4_bp;
            r5_c[0] <= XW'(r4_p[0]) - XW'(r4_p[1]);
            r5_c[1] <= XW'(r4_p[2]) - XW'(r4_p[3]);
            r5_c[2] <= XW'(r4_p[4]) - XW'(r4_p[5]);
            r5_sa   <= SW'(r4_qa[0]) + SW'(r4_qa[1]) + SW'(r4_qa[2]);
            r5_sb   <= SW'(r4_qb[0]) + SW'(r4_qb[1]) + SW'(r4_qb[2]);
            r6_ap <= r5_ap;
            r6_bp <= r5_bp;
            r6_c  <= r5_c;
            r6_sa <= r5_sa;
            r6_sb <= r5_sb;
            r6_cq <= n6_cq;
            for (int i = 0; i < 3; i++) begin
                r7_x[i]     <= XW'(r6_ap[i]);
                r7_x[3 + i] <= XW'(r6_bp[i]);
                r7_x[6 + i] <= r6_c[i];
                r7_s[i]     <= r6_sa;
                r7_s[3 + i] <= r6_sb;
                r7_s[6 + i] <= n7_sc;
            end
            r7_degen <= (r6_sa == '0) || (r6_sb == '0) || (n7_sc == '0);
        end
    end

    assign o_x     = r7_x;
    assign o_s     = r7_s;
    assign o_degen = r7_degen;
endmodule
`default_nettype wire

### design/dcm_lane.sv
// ----------------------------------------------------------------------------
// dcm_lane
// one element scaled to unit row length, exact rounding, one bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module dcm_lane import dcm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_elem i_x,
    input  t_sum  i_s,
    output t_data o_q
);
    logic              r0_neg;
    t_sum              r0_x2;
    t_sum              r0_s;
    logic signed [RW-1:0] r_rm [QW+1];
    logic signed [NW-1:0] r_d  [QW+1];
    t_sum              r_sl [QW+1];
    t_q                r_q  [QW+1];
    logic              r_ng [QW+1];
    t_data             r_out;

    logic [XW-1:0] n0_mag;
    logic signed [QW:0] n_sq;

    always_comb begin
        n0_mag = i_x[XW-1] ? XW'(-i_x) : XW'(i_x);
        n_sq   = $signed({1'b0, r_q[QW]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_neg  <= i_x[XW-1];
            r0_x2   <= SW'(n0_mag[MW-1:0]) * SW'(n0_mag[MW-1:0]);
            r0_s    <= i_s;
            r_rm[0] <= $signed((RW'(r0_x2) << (2 * FRAC_BITS + 2)) - RW'(r0_s));
            r_d[0]  <= -$signed(NW'(r0_s));
            r_sl[0] <= r0_s;
            r_q[0]  <= '0;
            r_ng[0] <= r0_neg;
            r_out   <= DW'(r_ng[QW] ? -n_sq : n_sq);
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_step
        localparam int K = QW - 1 - j;
        logic signed [RW-1:0] n_dt;
        logic signed [RW-1:0] n_st;
        logic signed [RW-1:0] n_trial;
        logic                 n_acc;

        always_comb begin
            n_dt    = RW'(r_d[j]) <<< (K + 2);
            n_st    = $signed(RW'(r_sl[j]) << (2 * K + 2));
            n_trial = r_rm[j] - n_dt - n_st;
            n_acc   = !n_trial[RW-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rm[j+1] <= n_acc ? n_trial : r_rm[j];
                r_d[j+1]  <= n_acc ? r_d[j] + $signed(NW'(r_sl[j]) << (K + 1)) : r_d[j];
                r_q[j+1]  <= r_q[j] | (QW'(n_acc) << K);
                r_sl[j+1] <= r_sl[j];
                r_ng[j+1] <= r_ng[j];
            end
        end
    end

    assign o_q = r_out;
endmodule
`default_nettype wire

### tb/sv/dcm_renormalize_core_test.sv
// ----------------------------------------------------------------------------
// dcm_renormalize_core_test
// Checks the direction cosine matrix renormalize core against a bit-true
// predictor. A short table of fixed matrices comes first, then random and
// near-orthonormal matrices. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
`default_nettype none
module dcm_renormalize_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dcm_pkg::*;

    typedef struct {
        t_data a [3];
        t_data b [3];
    } t_matrix_in;

    typedef struct {
        t_data e [9];
        logic  degen;
    } t_matrix_out;

    typedef struct {
        t_matrix_in  m;
        bit          typed;
        logic        degen;
    } t_table_row;

    localparam int NUM_RANDOM  = 1800;
    localparam int CYCLE_LIMIT = 400000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_data i_row_a_x, i_row_a_y, i_row_a_z;
    t_data i_row_b_x, i_row_b_y, i_row_b_z;
    logic  o_valid;
    logic  i_stall;
    t_data o_out_a_x, o_out_a_y, o_out_a_z;
    t_data o_out_b_x, o_out_b_y, o_out_b_z;
    t_data o_out_c_x, o_out_c_y, o_out_c_z;
    logic  o_degenerate;

    t_matrix_out expected_rows [$];
    int          mismatch_count;
    int          checked_count;
    int          degen_count;
    int          cycle_count;
    int          stall_mode;

    dcm_renormalize_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_row_a_x    (i_row_a_x),
        .i_row_a_y    (i_row_a_y),
        .i_row_a_z    (i_row_a_z),
        .i_row_b_x    (i_row_b_x),
        .i_row_b_y    (i_row_b_y),
        .i_row_b_z    (i_row_b_z),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_a_x    (o_out_a_x),
        .o_out_a_y    (o_out_a_y),
        .o_out_a_z    (o_out_a_z),
        .o_out_b_x    (o_out_b_x),
        .o_out_b_y    (o_out_b_y),
        .o_out_b_z    (o_out_b_z),
        .o_out_c_x    (o_out_c_x),
        .o_out_c_y    (o_out_c_y),
        .o_out_c_z    (o_out_c_z),
        .o_degenerate (o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint half_round_shift(longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 << FRAC_BITS)) >>> (FRAC_BITS + 1);
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // largest q with (2q-1)^2 * s <= 2^(2F+2) * x^2
    function automatic t_data unit_element(longint x, logic [127:0] s);
        logic [127:0] x2, rhs, d, lhs;
        longint       lo, hi, mid;
        lo = 0;
        hi = longint'(1) << FRAC_BITS;
        x2 = (x < 0) ? 128'(-x) : 128'(x);
        x2 = x2 * x2;
        rhs = x2 << (2 * FRAC_BITS + 2);
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            d = 128'(2 * mid - 1);
            lhs = d * d * s;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return t_data'((x < 0) ? -lo : lo);
    endfunction

    function automatic t_matrix_out renormalize(t_matrix_in m);
        t_matrix_out  r;
        longint       a [3], b [3], ap [3], bp [3], c [3];
        longint       err;
        logic [127:0] sa, sb, sc;
        err = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = m.a[i];
            b[i] = m.b[i];
            err += a[i] * b[i];
        end
        for (int i = 0; i < 3; i++) begin
            ap[i] = clamp16(a[i] - half_round_shift(b[i] * err));
            bp[i] = clamp16(b[i] - half_round_shift(a[i] * err));
        end
        c[0] = ap[1] * bp[2] - ap[2] * bp[1];
        c[1] = ap[2] * bp[0] - ap[0] * bp[2];
        c[2] = ap[0] * bp[1] - ap[1] * bp[0];
        sa = 0;
        sb = 0;
        sc = 0;
        for (int i = 0; i < 3; i++) begin
            sa += 128'(ap[i] * ap[i]);
            sb += 128'(bp[i] * bp[i]);
            sc += 128'(c[i] < 0 ? -c[i] : c[i]) * 128'(c[i] < 0 ? -c[i] : c[i]);
        end
        if (sa == 0 || sb == 0 || sc == 0) begin
            for (int i = 0; i < 9; i++) r.e[i] = (i % 4 == 0) ? ONE : '0;
            r.degen = 1'b1;
        end else begin
            for (int i = 0; i < 3; i++) begin
                r.e[i]     = unit_element(ap[i], sa);
                r.e[3 + i] = unit_element(bp[i], sb);
                r.e[6 + i] = unit_element(c[i], sc);
            end
            r.degen = 1'b0;
        end
        return r;
    endfunction

    function automatic t_matrix_out identity_result(logic degen);
        t_matrix_out r;
        for (int i = 0; i < 9; i++) r.e[i] = (i % 4 == 0) ? ONE : '0;
        r.degen = degen;
        return r;
    endfunction

    function automatic t_matrix_in make_matrix(int ax, int ay, int az, int bx, int by, int bz);
        t_matrix_in m;
        m.a[0] = t_data'(ax); m.a[1] = t_data'(ay); m.a[2] = t_data'(az);
        m.b[0] = t_data'(bx); m.b[1] = t_data'(by); m.b[2] = t_data'(bz);
        return m;
    endfunction

    function automatic t_data rand_word();
        return t_data'($urandom_range(0, 65535));
    endfunction

    // roughly orthonormal rows: signed axis permutation plus noise
    function automatic t_matrix_in near_rotation();
        t_matrix_in m;
        int         ia, ib, noise;
        ia = $urandom_range(0, 2);
        ib = (ia + $urandom_range(1, 2)) % 3;
        noise = ($urandom_range(0, 3) == 0) ? 8000 : 600;
        for (int i = 0; i < 3; i++) begin
            m.a[i] = t_data'($urandom_range(0, 2 * noise) - noise);
            m.b[i] = t_data'($urandom_range(0, 2 * noise) - noise);
        end
        m.a[ia] = m.a[ia] + ($urandom_range(0, 1) ? ONE : -ONE);
        m.b[ib] = m.b[ib] + ($urandom_range(0, 1) ? ONE : -ONE);
        return m;
    endfunction

    task automatic send_matrix(t_matrix_in m, bit typed, logic degen);
        i_valid   <= 1'b1;
        i_row_a_x <= m.a[0]; i_row_a_y <= m.a[1]; i_row_a_z <= m.a[2];
        i_row_b_x <= m.b[0]; i_row_b_y <= m.b[1]; i_row_b_z <= m.b[2];
        do @(posedge i_clk); while (o_stall);
        expected_rows.push_back(typed ? identity_result(degen) : renormalize(m));
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_matrix_out got, want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("dcm_renormalize_core verification failed");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got.e[0] = o_out_a_x; got.e[1] = o_out_a_y; got.e[2] = o_out_a_z;
            got.e[3] = o_out_b_x; got.e[4] = o_out_b_y; got.e[5] = o_out_b_z;
            got.e[6] = o_out_c_x; got.e[7] = o_out_c_y; got.e[8] = o_out_c_z;
            got.degen = o_degenerate;
            if (expected_rows.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected transfer at cycle %0d", cycle_count);
            end else begin
                want = expected_rows.pop_front();
                checked_count++;
                if (want.degen) degen_count++;
                for (int i = 0; i <= 9; i++) begin
                    if ((i < 9) ? (got.e[i] !== want.e[i]) : (got.degen !== want.degen)) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result %0d field %0d: expected %0d got %0d",
                                checked_count, i,
                                (i < 9) ? int'(want.e[i]) : int'(want.degen),
                                (i < 9) ? int'(got.e[i]) : int'(got.degen));
                    end
                end
            end
        end
    end

    initial begin
        t_table_row directed [$];
        t_matrix_in m;
        int         burst;
        bit         drained;
        cycle_count    = 0;
        mismatch_count = 0;
        checked_count  = 0;
        degen_count    = 0;
        stall_mode     = 0;
        drained        = 1'b0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_stall   = 1'b0;
        i_row_a_x = '0; i_row_a_y = '0; i_row_a_z = '0;
        i_row_b_x = '0; i_row_b_y = '0; i_row_b_z = '0;

        directed.push_back('{make_matrix(16384, 0, 0, 0, 16384, 0), 1, 1'b0});
        directed.push_back('{make_matrix(0, 0, 0, 0, 0, 0), 1, 1'b1});
        directed.push_back('{make_matrix(0, 0, 0, 0, 16384, 0), 1, 1'b1});
        directed.push_back('{make_matrix(16384, 0, 0, 0, 0, 0), 1, 1'b1});
        directed.push_back('{make_matrix(16384, 0, 0, 16384, 0, 0), 0, 1'b0});
        directed.push_back('{make_matrix(16384, 0, 0, -16384, 0, 0), 0, 1'b0});
        directed.push_back('{make_matrix(0, 0, 16384, 0, -16384, 0), 0, 1'b0});
        directed.push_back('{make_matrix(-32768, -32768, -32768, -32768, -32768, -32768), 0, 1'b0});
        directed.push_back('{make_matrix(32767, 32767, 32767, 32767, 32767, 32767), 0, 1'b0});
        directed.push_back('{make_matrix(32767, -32768, 32767, -32768, 32767, -32768), 0, 1'b0});
        directed.push_back('{make_matrix(32767, 0, 0, 0, -32768, 0), 0, 1'b0});
        directed.push_back('{make_matrix(1, 0, 0, 0, 1, 0), 0, 1'b0});
        directed.push_back('{make_matrix(-1, 0, 0, 0, 0, -1), 0, 1'b0});
        directed.push_back('{make_matrix(16384, 1000, -500, -900, 16384, 300), 0, 1'b0});
        directed.push_back('{make_matrix(11585, 11585, 0, -11585, 11585, 0), 0, 1'b0});
        directed.push_back('{make_matrix(9459, 9459, 9459, 9459, -9459, 0), 0, 1'b0});
        directed.push_back('{make_matrix(20000, 20000, 0, 20000, 20000, 1), 0, 1'b0});
        directed.push_back('{make_matrix(32767, 32767, 0, 32767, 32767, 0), 0, 1'b0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_matrix(directed[k].m, directed[k].typed, directed[k].degen);
            sender_gap();
        end

        for (int n = 0; n < NUM_RANDOM; ) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && n < NUM_RANDOM; j++, n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        for (int i = 0; i < 3; i++) begin
                            m.a[i] = rand_word();
                            m.b[i] = rand_word();
                        end
                    end
                    3: begin
                        m = near_rotation();
                        m.b = m.a;
                    end
                    4: begin
                        m = near_rotation();
                        m.a[$urandom_range(0, 2)] = rand_word();
                        if ($urandom_range(0, 1)) m.b = '{default: '0};
                    end
                    default: m = near_rotation();
                endcase
                send_matrix(m, 0, 1'b0);
            end
            i_valid <= 1'b0;
            if (!drained && n >= NUM_RANDOM / 2) begin
                drained = 1'b1;
                while (expected_rows.size() != 0) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (TOTAL_LAT + 10) @(posedge i_clk);

        $display("checked %0d matrices (%0d degenerate) over %0d cycles",
            checked_count, degen_count, cycle_count);
        if (mismatch_count == 0 && expected_rows.size() == 0) begin
            $display("dcm_renormalize_core verification clean");
        end else begin
            $display("mismatches: %0d", mismatch_count);
            $display("dcm_renormalize_core verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
